FILE: rtl/complex_arithmetic_unit_macros.svh
// ---------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared assertion forms used by the checker of the complex arithmetic unit.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked around reset.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, operation codes, the queued item type and saturation helpers.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int ADD_W     = DATA_W + 1;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int WIDE_W    = PROD_W + 1;
  localparam int QUO_BITS  = DATA_W + 1;
  localparam int MAG_W     = QUO_BITS + 1;
  localparam int DIV_SH    = QUO_BITS - FRAC_BITS;
  localparam int QUE_DEPTH = 4;
  localparam int QUE_AW    = 2;

  localparam logic [3:0] ACT_ADD    = 4'd0;
  localparam logic [3:0] ACT_SUB    = 4'd1;
  localparam logic [3:0] ACT_MUL    = 4'd2;
  localparam logic [3:0] ACT_DIV    = 4'd3;
  localparam logic [3:0] ACT_EQ     = 4'd4;
  localparam logic [3:0] ACT_NE     = 4'd5;
  localparam logic [3:0] ACT_NEG    = 4'd6;
  localparam logic [3:0] ACT_CONJ   = 4'd7;
  localparam logic [3:0] ACT_INC_RE = 4'd8;
  localparam logic [3:0] ACT_DEC_RE = 4'd9;
  localparam logic [3:0] ACT_INC_IM = 4'd10;
  localparam logic [3:0] ACT_DEC_IM = 4'd11;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_CMP  = 3'd4;

  localparam logic signed [ADD_W-1:0] ONE_Q = ADD_W'(2 ** FRAC_BITS);

  localparam logic signed [WIDE_W-1:0] SAT_HI =
    {{(WIDE_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO =
    {{(WIDE_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(1) << (DATA_W - 1);
  localparam logic [MAG_W-1:0] DIV_CAP = MAG_W'(1) << QUO_BITS;
  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic [2:0]               kind;
    logic                     cmp;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
    logic signed [ADD_W-1:0]  x_re;
    logic signed [ADD_W-1:0]  y_re;
    logic signed [ADD_W-1:0]  x_im;
    logic signed [ADD_W-1:0]  y_im;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] v;
    logic              ov;
  } sat_t;

  function automatic sat_t sat_wide(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if (x > SAT_HI) begin
      r.v  = POS_MAX;
      r.ov = 1'b1;
    end else if (x < SAT_LO) begin
      r.v  = NEG_MAX;
      r.ov = 1'b1;
    end else begin
      r.v  = x[DATA_W-1:0];
      r.ov = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    sat_t             r;
    logic [MAG_W-1:0] t;
    t = ~mag + MAG_W'(1);
    if (neg) begin
      if (mag > MAG_LIM) begin
        r.v  = NEG_MAX;
        r.ov = 1'b1;
      end else begin
        r.v  = t[DATA_W-1:0];
        r.ov = 1'b0;
      end
    end else begin
      if (mag >= MAG_LIM) begin
        r.v  = POS_MAX;
        r.ov = 1'b1;
      end else begin
        r.v  = mag[DATA_W-1:0];
        r.ov = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Fixed point complex ALU: add, subtract, multiply, divide, compare,
// negate, conjugate and unit steps on either part, with saturation.
// ---------------------------------------------------------------------------
// The input channel takes an action code and two complex operands in signed
// Q16.16; an item is taken when in_valid is high and in_stall is low.
// The output channel gives both result parts, the comparison outcome and the
// divide-by-zero and overflow flags; an item leaves when out_valid is high
// and out_stall is low.
// The restoring divider settles one quotient bit of both parts per stage
// over 33 stages; around it lie the queue, multiply, sum, magnitude, range
// check and output register stages. One item can be taken and one
// delivered in every cycle while out_stall is low and the queue is not full.
// A four-item queue separates the decoding front end from the datapath.
// While out_stall holds a waiting result, the whole datapath holds, and
// the input side keeps taking items until the queue is full.
// Reset empties the queue and clears every valid flag in the datapath.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [3:0]                         action,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_im,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cau_pkg::DATA_W-1:0]  res_re,
  output logic signed [cau_pkg::DATA_W-1:0]  res_im,
  output logic                               compare_true,
  output logic                               div_zero,
  output logic                               overflow
);

  cau_pkg::item_t f_item;
  cau_pkg::item_t q_item;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;
  logic           q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  cau_front u_front (
    .action (action),
    .a_re   (a_re),
    .a_im   (a_im),
    .b_re   (b_re),
    .b_im   (b_im),
    .item   (f_item)
  );

  cau_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .avail (q_avail)
  );

  cau_back u_back (
    .clk          (clk),
    .rst          (rst),
    .din          (q_item),
    .avail        (q_avail),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .res_re       (res_re),
    .res_im       (res_im),
    .compare_true (compare_true),
    .div_zero     (div_zero),
    .overflow     (overflow)
  );

endmodule

FILE: rtl/cau_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Decodes the action of an incoming item into an execution class and
// forms the addends and comparison outcome of the simple operations.
// ---------------------------------------------------------------------------
module cau_front (
  input  logic [3:0]                         action,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_re,
  input  logic signed [cau_pkg::DATA_W-1:0]  a_im,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_re,
  input  logic signed [cau_pkg::DATA_W-1:0]  b_im,
  output cau_pkg::item_t                     item
);

  localparam int AW = cau_pkg::ADD_W;

  logic signed [AW-1:0] ar, ai, br, bi;

  assign ar = AW'(a_re);
  assign ai = AW'(a_im);
  assign br = AW'(b_re);
  assign bi = AW'(b_im);

  always_comb begin
    item      = '0;
    item.kind = cau_pkg::KIND_NONE;
    item.a_re = a_re;
    item.a_im = a_im;
    item.b_re = b_re;
    item.b_im = b_im;
    case (action)
      cau_pkg::ACT_ADD: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.y_re = br;
        item.x_im = ai;
        item.y_im = bi;
      end
      cau_pkg::ACT_SUB: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.y_re = -br;
        item.x_im = ai;
        item.y_im = -bi;
      end
      cau_pkg::ACT_MUL: item.kind = cau_pkg::KIND_MUL;
      cau_pkg::ACT_DIV: item.kind = cau_pkg::KIND_DIV;
      cau_pkg::ACT_EQ: begin
        item.kind = cau_pkg::KIND_CMP;
        item.cmp  = (a_re == b_re) && (a_im == b_im);
      end
      cau_pkg::ACT_NE: begin
        item.kind = cau_pkg::KIND_CMP;
        item.cmp  = (a_re != b_re) || (a_im != b_im);
      end
      cau_pkg::ACT_NEG: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = -ar;
        item.x_im = -ai;
      end
      cau_pkg::ACT_CONJ: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.x_im = -ai;
      end
      cau_pkg::ACT_INC_RE: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.y_re = cau_pkg::ONE_Q;
        item.x_im = ai;
      end
      cau_pkg::ACT_DEC_RE: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.y_re = -cau_pkg::ONE_Q;
        item.x_im = ai;
      end
      cau_pkg::ACT_INC_IM: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.x_im = ai;
        item.y_im = cau_pkg::ONE_Q;
      end
      cau_pkg::ACT_DEC_IM: begin
        item.kind = cau_pkg::KIND_ADD;
        item.x_re = ar;
        item.x_im = ai;
        item.y_im = -cau_pkg::ONE_Q;
      end
      default: item.kind = cau_pkg::KIND_NONE;
    endcase
  end

endmodule

FILE: rtl/cau_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit item queue
// A short first-in first-out queue between the front end and the datapath.
// ---------------------------------------------------------------------------
module cau_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cau_pkg::item_t din,
  output logic           full,
  input  logic           pop,
  output cau_pkg::item_t dout,
  output logic           avail
);

  localparam int AW = cau_pkg::QUE_AW;

  cau_pkg::item_t mem [cau_pkg::QUE_DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;

  assign full  = count == (AW + 1)'(cau_pkg::QUE_DEPTH);
  assign avail = count != '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/cau_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit datapath
// Multiplies, sums and saturates, then runs the two quotient parts through
// a pipelined restoring divider of one quotient bit per stage.
// ---------------------------------------------------------------------------
module cau_back (
  input  logic                               clk,
  input  logic                               rst,
  input  cau_pkg::item_t                     din,
  input  logic                               avail,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cau_pkg::DATA_W-1:0]  res_re,
  output logic signed [cau_pkg::DATA_W-1:0]  res_im,
  output logic                               compare_true,
  output logic                               div_zero,
  output logic                               overflow
);

  localparam int DW = cau_pkg::DATA_W;
  localparam int AW = cau_pkg::ADD_W;
  localparam int PW = cau_pkg::PROD_W;
  localparam int WW = cau_pkg::WIDE_W;
  localparam int QB = cau_pkg::QUO_BITS;
  localparam int SH = cau_pkg::DIV_SH;
  localparam int FB = cau_pkg::FRAC_BITS;

  typedef struct packed {
    logic [2:0]    kind;
    logic          cmp;
    logic          ov;
    logic [DW-1:0] re;
    logic [DW-1:0] im;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic          big_re;
    logic          big_im;
    logic [PW-1:0] n_re;
    logic [PW-1:0] n_im;
    logic [PW-1:0] d;
    logic [PW-1:0] r_re;
    logic [PW-1:0] r_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
  } div_t;

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && avail;

  logic                 s1_vld;
  logic [2:0]           s1_kind;
  logic                 s1_cmp;
  logic signed [AW:0]   s1_sum_re, s1_sum_im;
  logic signed [PW-1:0] s1_rr, s1_ii, s1_ri, s1_ir, s1_br2, s1_bi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= avail;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind   <= din.kind;
      s1_cmp    <= din.cmp;
      s1_sum_re <= (AW + 1)'(din.x_re) + (AW + 1)'(din.y_re);
      s1_sum_im <= (AW + 1)'(din.x_im) + (AW + 1)'(din.y_im);
      s1_rr     <= PW'(din.a_re) * PW'(din.b_re);
      s1_ii     <= PW'(din.a_im) * PW'(din.b_im);
      s1_ri     <= PW'(din.a_re) * PW'(din.b_im);
      s1_ir     <= PW'(din.a_im) * PW'(din.b_re);
      s1_br2    <= PW'(din.b_re) * PW'(din.b_re);
      s1_bi2    <= PW'(din.b_im) * PW'(din.b_im);
    end
  end

  logic                 s2_vld;
  logic [2:0]           s2_kind;
  logic                 s2_cmp;
  logic                 s2_ov;
  logic [DW-1:0]        s2_re, s2_im;
  logic signed [WW-1:0] s2_nre, s2_nim;
  logic [PW-1:0]        s2_d;

  cau_pkg::sat_t        ad_re, ad_im, mu_re, mu_im;
  logic signed [WW-1:0] mw_re, mw_im;
  logic [DW-1:0]        s2_re_next, s2_im_next;
  logic                 s2_ov_next;

  always_comb begin
    ad_re = cau_pkg::sat_wide(WW'(s1_sum_re));
    ad_im = cau_pkg::sat_wide(WW'(s1_sum_im));
    mw_re = (WW'(s1_rr) - WW'(s1_ii)) >>> FB;
    mw_im = (WW'(s1_ri) + WW'(s1_ir)) >>> FB;
    mu_re = cau_pkg::sat_wide(mw_re);
    mu_im = cau_pkg::sat_wide(mw_im);
    s2_re_next = '0;
    s2_im_next = '0;
    s2_ov_next = 1'b0;
    case (s1_kind)
      cau_pkg::KIND_ADD: begin
        s2_re_next = ad_re.v;
        s2_im_next = ad_im.v;
        s2_ov_next = ad_re.ov || ad_im.ov;
      end
      cau_pkg::KIND_MUL: begin
        s2_re_next = mu_re.v;
        s2_im_next = mu_im.v;
        s2_ov_next = mu_re.ov || mu_im.ov;
      end
      default: s2_ov_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind <= s1_kind;
      s2_cmp  <= s1_cmp;
      s2_ov   <= s2_ov_next;
      s2_re   <= s2_re_next;
      s2_im   <= s2_im_next;
      s2_nre  <= WW'(s1_rr) + WW'(s1_ii);
      s2_nim  <= WW'(s1_ir) - WW'(s1_ri);
      s2_d    <= s1_br2 + s1_bi2;
    end
  end

  logic                 s3_vld;
  div_t                 s3;
  div_t                 s3_next;
  logic signed [WW-1:0] ng_re, ng_im;

  always_comb begin
    ng_re          = -s2_nre;
    ng_im          = -s2_nim;
    s3_next        = '0;
    s3_next.kind   = s2_kind;
    s3_next.cmp    = s2_cmp;
    s3_next.ov     = s2_ov;
    s3_next.re     = s2_re;
    s3_next.im     = s2_im;
    s3_next.d      = s2_d;
    s3_next.dz     = s2_d == '0;
    s3_next.neg_re = s2_nre[WW-1];
    s3_next.neg_im = s2_nim[WW-1];
    s3_next.n_re   = s2_nre[WW-1] ? ng_re[PW-1:0] : s2_nre[PW-1:0];
    s3_next.n_im   = s2_nim[WW-1] ? ng_im[PW-1:0] : s2_nim[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
    end
  end

  logic [QB:0] vld;
  div_t        dv [QB+1];
  div_t        dv0_next;

  always_comb begin
    dv0_next        = s3;
    dv0_next.big_re = {{SH{1'b0}}, s3.n_re} >= {s3.d, {SH{1'b0}}};
    dv0_next.big_im = {{SH{1'b0}}, s3.n_im} >= {s3.d, {SH{1'b0}}};
    dv0_next.r_re   = s3.n_re >> SH;
    dv0_next.r_im   = s3.n_im >> SH;
    dv0_next.q_re   = '0;
    dv0_next.q_im   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv0_next;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic        xb_re, xb_im, ge_re, ge_im;
    logic [PW:0] r2_re, r2_im, df_re, df_im, dd;
    div_t        nx;

    if (K >= FB) begin : g_bit
      assign xb_re = dv[j].n_re[K-FB];
      assign xb_im = dv[j].n_im[K-FB];
    end else begin : g_zero
      assign xb_re = 1'b0;
      assign xb_im = 1'b0;
    end

    always_comb begin
      nx      = dv[j];
      dd      = {1'b0, dv[j].d};
      r2_re   = {dv[j].r_re, xb_re};
      r2_im   = {dv[j].r_im, xb_im};
      df_re   = r2_re - dd;
      df_im   = r2_im - dd;
      ge_re   = r2_re >= dd;
      ge_im   = r2_im >= dd;
      nx.r_re = ge_re ? df_re[PW-1:0] : r2_re[PW-1:0];
      nx.r_im = ge_im ? df_im[PW-1:0] : r2_im[PW-1:0];
      nx.q_re = {dv[j].q_re[QB-2:0], ge_re};
      nx.q_im = {dv[j].q_im[QB-2:0], ge_im};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= nx;
      end
    end
  end

  cau_pkg::sat_t fq_re, fq_im;
  logic [DW-1:0] o_re, o_im;
  logic          o_cmp, o_dz, o_ov;

  always_comb begin
    fq_re = cau_pkg::sat_mag(dv[QB].neg_re,
                             dv[QB].big_re ? cau_pkg::DIV_CAP : {1'b0, dv[QB].q_re});
    fq_im = cau_pkg::sat_mag(dv[QB].neg_im,
                             dv[QB].big_im ? cau_pkg::DIV_CAP : {1'b0, dv[QB].q_im});
    o_re  = dv[QB].re;
    o_im  = dv[QB].im;
    o_cmp = dv[QB].cmp;
    o_ov  = dv[QB].ov;
    o_dz  = 1'b0;
    if (dv[QB].kind == cau_pkg::KIND_DIV) begin
      o_cmp = 1'b0;
      if (dv[QB].dz) begin
        o_re = '0;
        o_im = '0;
        o_ov = 1'b0;
        o_dz = 1'b1;
      end else begin
        o_re = fq_re.v;
        o_im = fq_im.v;
        o_ov = fq_re.ov || fq_im.ov;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re       <= o_re;
      res_im       <= o_im;
      compare_true <= o_cmp;
      div_zero     <= o_dz;
      overflow     <= o_ov;
    end
  end

endmodule

FILE: rtl/cau_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [cau_pkg::DATA_W-1:0]  res_re,
  input logic signed [cau_pkg::DATA_W-1:0]  res_im,
  input logic                               compare_true,
  input logic                               div_zero,
  input logic                               overflow
);

  `CAU_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(res_im), "stalled result changed")
  `CAU_ASSERT(a_dz_zero, out_valid && div_zero |-> res_re == 0 && res_im == 0 && !overflow && !compare_true, "divide by zero result not clean")
  `CAU_ASSERT(a_cmp_zero, out_valid && compare_true |-> res_re == 0 && res_im == 0 && !overflow && !div_zero, "comparison result not clean")
  `CAU_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
